>>> hw/rtl/cooperative_task_timer_table_core_assert.svh
// ----------------------------------------------------------------------------
// Cooperative task timer table - assertion macros
// Shared concurrent assertion forms for the timer table RTL.
// ----------------------------------------------------------------------------
`ifndef COOPERATIVE_TASK_TIMER_TABLE_CORE_ASSERT_SVH
`define COOPERATIVE_TASK_TIMER_TABLE_CORE_ASSERT_SVH

// check a property at every rising clock edge outside reset
`define CTTT_ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition implies another one on the following edge
`define CTTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/cttt_pkg.sv
// ----------------------------------------------------------------------------
// Cooperative task timer table - package
// Types, codes and constants shared by the timer table modules.
// ----------------------------------------------------------------------------
package cttt_pkg;

    localparam int MAX_TASKS_DEF = 8;
    localparam int RESULT_LIMIT  = 8;
    localparam int RW            = $clog2(RESULT_LIMIT + 1);

    localparam int CD_W   = 16;
    localparam int TAG_W  = 8;
    localparam int SLOT_W = 3;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_TICK     = 2'd1,
        OP_DISPATCH = 2'd2,
        OP_DELETE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_SLOT = 2'd2,
        ST_NONE     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        TB_HOLD,
        TB_APPEND,
        TB_ROTATE,
        TB_DROP
    } tbl_op_t;

    typedef enum logic {
        SQ_IDLE,
        SQ_WALK
    } seq_state_t;

    typedef struct packed {
        logic [CD_W-1:0]  countdown;
        logic [CD_W-1:0]  period;
        logic             ready;
        logic [TAG_W-1:0] tag;
    } entry_t;

    typedef struct packed {
        tbl_op_t op;
        entry_t  data;
    } tbl_cmd_t;

    typedef struct packed {
        entry_t head;
        logic   drop;
        logic   emit;
        logic   ready_inc;
        logic   ready_dec;
    } step_res_t;

endpackage

>>> hw/rtl/cttt_step_unit.sv
// ----------------------------------------------------------------------------
// Cooperative task timer table - entry step unit
// Shared per-entry datapath: tick decrement and reload, dispatch ready test,
// delete slot match. Applied to the head once a cycle unless stalled.
// ----------------------------------------------------------------------------
module cttt_step_unit
    import cttt_pkg::*;
#(
    parameter int CW = 4
) (
    input  entry_t          head,
    input  op_t             op,
    input  logic            emit_ok,
    input  logic [CW-1:0]   walk_idx,
    input  logic [CW-1:0]   target,
    output step_res_t       res
);

    logic            cd_nonzero;
    logic            cd_expire;
    logic [CD_W-1:0] cd_dec;

    assign cd_nonzero = (head.countdown != '0);
    assign cd_expire  = (head.countdown == CD_W'(1));
    assign cd_dec     = head.countdown - CD_W'(1);

    always_comb begin
        res           = '0;
        res.head      = head;
        case (op)
            OP_TICK: begin
                if (cd_nonzero) begin
                    res.head.countdown = cd_expire ? head.period : cd_dec;
                    res.head.ready     = head.ready | cd_expire;
                    res.ready_inc      = cd_expire & ~head.ready;
                end
            end
            OP_DISPATCH: begin
                if (head.ready && emit_ok) begin
                    res.emit       = 1'b1;
                    res.head.ready = 1'b0;
                    res.ready_dec  = 1'b1;
                    res.drop       = (head.period == '0);
                end
            end
            OP_DELETE: begin
                if (walk_idx == target) begin
                    res.drop      = 1'b1;
                    res.ready_dec = head.ready;
                end
            end
            default: begin
                res.head = head;
            end
        endcase
    end

endmodule

>>> hw/rtl/cttt_table.sv
// ----------------------------------------------------------------------------
// Cooperative task timer table - entry store
// Compact entry table in slots 0 .. count-1. The head is slot 0; a rotate
// moves the updated head behind the last live entry, a drop discards it.
// ----------------------------------------------------------------------------
module cttt_table
    import cttt_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int CW        = $clog2(MAX_TASKS + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  tbl_cmd_t      cmd,
    output entry_t        head,
    output logic [CW-1:0] count
);

    entry_t        ent_reg [MAX_TASKS];
    entry_t        ent_up  [MAX_TASKS];
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    for (genvar k = 0; k < MAX_TASKS; k++) begin : g_ent
        localparam logic [CW-1:0] K_POS  = CW'(k);
        localparam logic [CW-1:0] K_NEXT = CW'(k + 1);

        if (k < MAX_TASKS - 1) begin : g_up
            assign ent_up[k] = ent_reg[k + 1];
        end else begin : g_end
            assign ent_up[k] = cmd.data;
        end

        always_ff @(posedge aclk) begin
            case (cmd.op)
                TB_APPEND: begin
                    if (K_POS == cnt_reg) ent_reg[k] <= cmd.data;
                end
                TB_ROTATE: begin
                    if (K_NEXT == cnt_reg) ent_reg[k] <= cmd.data;
                    else if (K_NEXT < cnt_reg) ent_reg[k] <= ent_up[k];
                end
                TB_DROP: begin
                    if (K_NEXT < cnt_reg) ent_reg[k] <= ent_up[k];
                end
                default: begin
                    ent_reg[k] <= ent_reg[k];
                end
            endcase
        end
    end

    always_comb begin
        case (cmd.op)
            TB_APPEND: cnt_next = cnt_reg + CW'(1);
            TB_DROP:   cnt_next = cnt_reg - CW'(1);
            default:   cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    assign head  = ent_reg[0];
    assign count = cnt_reg;

endmodule

>>> hw/rtl/cttt_seq.sv
// ----------------------------------------------------------------------------
// Cooperative task timer table - sequencer
// Takes requests, runs add directly and walks the table for tick, dispatch
// and delete through the shared step unit. Holds the result register.
// ----------------------------------------------------------------------------
`include "cooperative_task_timer_table_core_assert.svh"

module cttt_seq
    import cttt_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int CW        = $clog2(MAX_TASKS + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  op_t               req_op,
    input  logic [CD_W-1:0]   req_delay,
    input  logic [CD_W-1:0]   req_period,
    input  logic [TAG_W-1:0]  req_tag,
    input  logic [SLOT_W-1:0] req_target,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [SLOT_W-1:0] rsp_slot,
    output logic [TAG_W-1:0]  rsp_tag,
    output status_t           rsp_status,
    output logic              rsp_last,
    output tbl_cmd_t          tbl_cmd,
    input  entry_t            tbl_head,
    input  logic [CW-1:0]     tbl_count
);

    seq_state_t        state_reg, state_next;
    op_t               op_reg;
    logic [CW-1:0]     n0_reg, walk_reg, kept_reg, target_reg, rdy_cnt_reg;
    logic [RW-1:0]     emit_reg, total_reg;

    logic              out_valid_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [TAG_W-1:0]  out_tag_reg;
    status_t           out_status_reg;
    logic              out_last_reg;

    logic              out_free, accept, step, walk_done, emit_ok, target_ok;
    logic              out_load, start_walk;
    logic [SLOT_W-1:0] load_slot;
    logic [TAG_W-1:0]  load_tag;
    status_t           load_status;
    logic              load_last;
    step_res_t         sres;

    assign out_free  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign emit_ok   = (emit_reg < total_reg);
    assign target_ok = (32'(req_target) < 32'(tbl_count));
    assign walk_done = (CW'(walk_reg + CW'(1)) == n0_reg);

    cttt_step_unit #(
        .CW (CW)
    ) u_step (
        .head     (tbl_head),
        .op       (op_reg),
        .emit_ok  (emit_ok),
        .walk_idx (walk_reg),
        .target   (target_reg),
        .res      (sres)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SQ_IDLE: if (start_walk) state_next = SQ_WALK;
            SQ_WALK: if (step && walk_done) state_next = SQ_IDLE;
            default: state_next = SQ_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        step        = 1'b0;
        start_walk  = 1'b0;
        out_load    = 1'b0;
        load_slot   = '0;
        load_tag    = '0;
        load_status = ST_OK;
        load_last   = 1'b1;
        tbl_cmd.op  = TB_HOLD;
        tbl_cmd.data = sres.head;
        case (state_reg)
            SQ_IDLE: begin
                s_tready = out_free;
                if (accept) begin
                    case (req_op)
                        OP_ADD: begin
                            out_load = 1'b1;
                            if (32'(tbl_count) >= MAX_TASKS) begin
                                load_status = ST_FULL;
                            end else begin
                                load_slot          = SLOT_W'(tbl_count);
                                tbl_cmd.op         = TB_APPEND;
                                tbl_cmd.data.countdown = req_delay;
                                tbl_cmd.data.period    = req_period;
                                tbl_cmd.data.ready     = 1'b0;
                                tbl_cmd.data.tag       = req_tag;
                            end
                        end
                        OP_TICK: begin
                            start_walk = (tbl_count != '0);
                        end
                        OP_DISPATCH: begin
                            if (rdy_cnt_reg == '0) begin
                                out_load    = 1'b1;
                                load_status = ST_NONE;
                            end else begin
                                start_walk = 1'b1;
                            end
                        end
                        OP_DELETE: begin
                            out_load    = 1'b1;
                            load_slot   = req_target;
                            load_status = target_ok ? ST_OK : ST_BAD_SLOT;
                            start_walk  = target_ok;
                        end
                        default: begin
                            out_load = 1'b0;
                        end
                    endcase
                end
            end
            SQ_WALK: begin
                step = !sres.emit || out_free;
                if (step) begin
                    tbl_cmd.op = sres.drop ? TB_DROP : TB_ROTATE;
                    if (sres.emit) begin
                        out_load  = 1'b1;
                        load_slot = SLOT_W'(kept_reg);
                        load_tag  = tbl_head.tag;
                        load_last = (RW'(emit_reg + RW'(1)) == total_reg);
                    end
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= SQ_IDLE;
            rdy_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (step) begin
                rdy_cnt_reg <= rdy_cnt_reg + CW'(sres.ready_inc) - CW'(sres.ready_dec);
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= req_op;
            n0_reg     <= tbl_count;
            walk_reg   <= '0;
            kept_reg   <= '0;
            emit_reg   <= '0;
            target_reg <= CW'(req_target);
            if (32'(rdy_cnt_reg) > RESULT_LIMIT) total_reg <= RW'(RESULT_LIMIT);
            else total_reg <= RW'(rdy_cnt_reg);
        end else if (step) begin
            walk_reg <= walk_reg + CW'(1);
            if (!sres.drop) kept_reg <= kept_reg + CW'(1);
            if (sres.emit) emit_reg <= emit_reg + RW'(1);
        end
        if (out_load) begin
            out_slot_reg   <= load_slot;
            out_tag_reg    <= load_tag;
            out_status_reg <= load_status;
            out_last_reg   <= load_last;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign rsp_slot   = out_slot_reg;
    assign rsp_tag    = out_tag_reg;
    assign rsp_status = out_status_reg;
    assign rsp_last   = out_last_reg;

    `CTTT_ASSERT_HOLDS(a_rdy_le_count, aclk, aresetn, rdy_cnt_reg <= tbl_count, "ready count exceeds entries")
    `CTTT_ASSERT_NEXT(a_idle_count_stable, aclk, aresetn, state_reg == SQ_IDLE && !accept, $stable(tbl_count), "table count moved while idle")
    `CTTT_ASSERT_HOLDS(a_emit_bound, aclk, aresetn, state_reg != SQ_WALK || emit_reg <= total_reg, "more results than allowed")
    `CTTT_ASSERT_HOLDS(a_kept_le_walk, aclk, aresetn, state_reg != SQ_WALK || kept_reg <= walk_reg, "slot ahead of walk position")

endmodule

>>> hw/rtl/cooperative_task_timer_table_core.sv
// ----------------------------------------------------------------------------
// Cooperative task timer table - top level
// Compact table of timed tasks with add, tick, dispatch and delete requests.
// ----------------------------------------------------------------------------
// Add and an invalid delete or an empty dispatch finish in the accept cycle.
// Tick, dispatch and a valid delete walk the table one entry per cycle,
// up to MAX_TASKS live entries, through a single shared step unit; the
// walk stalls while a result waits on the result side, and no new
// request is taken during the walk.
module cooperative_task_timer_table_core
    import cttt_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // start_delay[15:0], repeat_period[31:16],
                                  // task_tag[39:32], target_slot[42:40]
    input  logic [1:0]  s_tuser,  // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // slot_index[2:0], tag_out[10:3]
    output logic [1:0]  m_tuser,  // status[1:0]
    output logic        m_tlast
);

    localparam int CW = $clog2(MAX_TASKS + 1);

    tbl_cmd_t          tbl_cmd;
    entry_t            tbl_head;
    logic [CW-1:0]     tbl_count;
    logic [SLOT_W-1:0] rsp_slot;
    logic [TAG_W-1:0]  rsp_tag;
    status_t           rsp_status;

    cttt_table #(
        .MAX_TASKS (MAX_TASKS),
        .CW        (CW)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (tbl_cmd),
        .head    (tbl_head),
        .count   (tbl_count)
    );

    cttt_seq #(
        .MAX_TASKS (MAX_TASKS),
        .CW        (CW)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .req_op     (op_t'(s_tuser)),
        .req_delay  (s_tdata[15:0]),
        .req_period (s_tdata[31:16]),
        .req_tag    (s_tdata[39:32]),
        .req_target (s_tdata[42:40]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .rsp_slot   (rsp_slot),
        .rsp_tag    (rsp_tag),
        .rsp_status (rsp_status),
        .rsp_last   (m_tlast),
        .tbl_cmd    (tbl_cmd),
        .tbl_head   (tbl_head),
        .tbl_count  (tbl_count)
    );

    assign m_tdata = {5'd0, rsp_tag, rsp_slot};
    assign m_tuser = rsp_status;

endmodule

>>> tb/tb_cooperative_task_timer_table_core.sv
// ----------------------------------------------------------------------------
// Cooperative task timer table - testbench
// Sends add, tick, dispatch and delete requests on the input stream and
// checks every result against a cycle-free model of the task table that is
// kept here. Directed requests hit the empty table, field extremes, one-shot
// removal during dispatch, zero start delay and table overflow; random
// traffic, with and without bursty stalls on both sides, follows.
// ----------------------------------------------------------------------------
module tb_cooperative_task_timer_table_core;
    import cttt_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [TAG_W-1:0]  tag;
        status_t           status;
        logic              last;
    } task_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = OP_ADD;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    logic [CD_W-1:0]  slot_countdown [MAX_TASKS_DEF];
    logic [CD_W-1:0]  slot_period    [MAX_TASKS_DEF];
    logic             slot_ready     [MAX_TASKS_DEF];
    logic             slot_active    [MAX_TASKS_DEF];
    logic [TAG_W-1:0] slot_tag       [MAX_TASKS_DEF];
    int               live_entries;

    task_result_t pending_results[$];
    task_result_t received_results[$];

    bit src_idle_on  = 1'b0;
    bit sink_idle_on = 1'b0;
    int stall_left   = 0;
    int quiet_cycles = 0;
    int mismatches   = 0;
    int results_seen = 0;
    int status_seen [4];
    int op_sent     [4];

    cooperative_task_timer_table_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ---------------- task table model ----------------

    function automatic void clear_table();
        for (int k = 0; k < MAX_TASKS_DEF; k++) begin
            slot_countdown[k] = '0;
            slot_period[k]    = '0;
            slot_ready[k]     = 1'b0;
            slot_active[k]    = 1'b0;
            slot_tag[k]       = '0;
        end
        live_entries = 0;
    endfunction

    function automatic void remove_slot(int s);
        for (int k = s; k + 1 < live_entries; k++) begin
            slot_countdown[k] = slot_countdown[k+1];
            slot_period[k]    = slot_period[k+1];
            slot_ready[k]     = slot_ready[k+1];
            slot_active[k]    = slot_active[k+1];
            slot_tag[k]       = slot_tag[k+1];
        end
        live_entries--;
        slot_countdown[live_entries] = '0;
        slot_period[live_entries]    = '0;
        slot_ready[live_entries]     = 1'b0;
        slot_active[live_entries]    = 1'b0;
        slot_tag[live_entries]       = '0;
    endfunction

    function automatic void advance_task_table(op_t op, logic [CD_W-1:0] delay,
                                               logic [CD_W-1:0] period,
                                               logic [TAG_W-1:0] tag,
                                               logic [SLOT_W-1:0] target);
        task_result_t batch[$];
        int i;
        case (op)
            OP_ADD: begin
                if (live_entries >= MAX_TASKS_DEF) begin
                    batch.push_back('{'0, '0, ST_FULL, 1'b1});
                end else begin
                    slot_countdown[live_entries] = delay;
                    slot_period[live_entries]    = period;
                    slot_ready[live_entries]     = 1'b0;
                    slot_active[live_entries]    = 1'b1;
                    slot_tag[live_entries]       = tag;
                    batch.push_back('{SLOT_W'(live_entries), '0, ST_OK, 1'b1});
                    live_entries++;
                end
            end
            OP_TICK: begin
                for (int k = 0; k < live_entries; k++) begin
                    if (slot_active[k] && slot_countdown[k] != 0) begin
                        slot_countdown[k]--;
                        if (slot_countdown[k] == 0) begin
                            slot_ready[k] = 1'b1;
                            if (slot_period[k] != 0) slot_countdown[k] = slot_period[k];
                        end
                    end
                end
            end
            OP_DISPATCH: begin
                i = 0;
                while (i < live_entries && batch.size() < RESULT_LIMIT) begin
                    if (slot_active[i] && slot_ready[i]) begin
                        slot_ready[i] = 1'b0;
                        batch.push_back('{SLOT_W'(i), slot_tag[i], ST_OK, 1'b0});
                        if (slot_period[i] == 0) begin
                            remove_slot(i);
                            continue;
                        end
                    end
                    i++;
                end
                if (batch.size() == 0) batch.push_back('{'0, '0, ST_NONE, 1'b1});
                else batch[batch.size()-1].last = 1'b1;
            end
            default: begin
                if (target >= live_entries || !slot_active[target]) begin
                    batch.push_back('{target, '0, ST_BAD_SLOT, 1'b1});
                end else begin
                    remove_slot(target);
                    batch.push_back('{target, '0, ST_OK, 1'b1});
                end
            end
        endcase
        foreach (batch[k]) pending_results.push_back(batch[k]);
    endfunction

    // ---------------- stream drivers ----------------

    task automatic send_request(op_t op, logic [CD_W-1:0] delay, logic [CD_W-1:0] period,
                                logic [TAG_W-1:0] tag, logic [SLOT_W-1:0] target);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, target, tag, period, delay};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        advance_task_table(op, delay, period, tag, target);
        op_sent[op]++;
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------- result checking ----------------

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            received_results.push_back('{m_tdata[2:0], m_tdata[10:3], status_t'(m_tuser),
                                         m_tlast});
    end

    always @(negedge aclk) begin
        task_result_t got;
        task_result_t want;
        while (received_results.size() != 0) begin
            got = received_results.pop_front();
            results_seen++;
            status_seen[got.status]++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: slot=%0d tag=%02h status=%0d last=%b",
                             got.slot, got.tag, got.status, got.last);
            end else begin
                want = pending_results.pop_front();
                if (got.slot !== want.slot || got.tag !== want.tag ||
                    got.status !== want.status || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("mismatch: expected slot=%0d tag=%02h status=%0d last=%b, %s",
                                 want.slot, want.tag, want.status, want.last,
                                 $sformatf("got slot=%0d tag=%02h status=%0d last=%b",
                                           got.slot, got.tag, got.status, got.last));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request or result moved for %0d cycles", quiet_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------- tests ----------------

    task automatic test_empty_table();
        send_request(OP_DISPATCH, 16'h0000, 16'h0000, 8'h00, 3'd0);
        send_request(OP_DELETE, 16'h0000, 16'h0000, 8'h00, 3'd0);
        send_request(OP_DELETE, 16'hFFFF, 16'hFFFF, 8'hFF, 3'd7);
    endtask

    task automatic test_one_shot_and_periodic();
        send_request(OP_ADD, 16'h0001, 16'h0000, 8'hFF, 3'd7);
        send_request(OP_ADD, 16'hFFFF, 16'hFFFF, 8'h00, 3'd0);
        send_request(OP_ADD, 16'h0000, 16'h0000, 8'h5A, 3'd5);
        send_request(OP_ADD, 16'h0001, 16'h0001, 8'hA5, 3'd2);
        send_request(OP_TICK, 16'h1234, 16'h4321, 8'h3C, 3'd6);
        send_request(OP_DISPATCH, 16'h0000, 16'h0000, 8'h00, 3'd0);
        send_request(OP_TICK, 16'h0000, 16'h0000, 8'h00, 3'd0);
        send_request(OP_DISPATCH, 16'hFFFF, 16'hFFFF, 8'hFF, 3'd7);
        send_request(OP_DELETE, 16'h0000, 16'h0000, 8'h00, 3'd1);
        send_request(OP_DELETE, 16'h0000, 16'h0000, 8'h00, 3'd5);
    endtask

    task automatic test_full_table();
        for (int k = 0; k < 6; k++)
            send_request(OP_ADD, 16'h0001, (k % 2 == 0) ? 16'h0000 : 16'h0002,
                         8'(8'h10 + k), 3'(k));
        send_request(OP_ADD, 16'h0003, 16'h0003, 8'hEE, 3'd4);
        send_request(OP_TICK, 16'h0000, 16'h0000, 8'h00, 3'd0);
        send_request(OP_DISPATCH, 16'h0000, 16'h0000, 8'h00, 3'd0);
        send_request(OP_DELETE, 16'h0000, 16'h0000, 8'h00, 3'd0);
    endtask

    task automatic test_random_traffic(int count, bit idle_on);
        int        roll;
        op_t       op;
        logic [15:0] delay;
        logic [15:0] period;
        logic [2:0]  target;
        src_idle_on = idle_on;
        sink_idle_on <= idle_on;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            op = (roll < 28) ? OP_ADD : (roll < 60) ? OP_TICK :
                 (roll < 82) ? OP_DISPATCH : OP_DELETE;
            roll = $urandom_range(0, 9);
            delay = (roll < 7) ? 16'($urandom_range(1, 5)) :
                    (roll < 8) ? 16'd0 : 16'($urandom_range(0, 65535));
            roll = $urandom_range(0, 9);
            period = (roll < 4) ? 16'd0 : (roll < 8) ? 16'($urandom_range(1, 6)) :
                     16'($urandom_range(0, 65535));
            if (live_entries > 0 && $urandom_range(0, 9) < 7)
                target = 3'($urandom_range(0, live_entries - 1));
            else
                target = 3'($urandom_range(0, 7));
            send_request(op, delay, period, 8'($urandom_range(0, 255)), target);
        end
    endtask

    initial begin
        clear_table();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_table();
        test_one_shot_and_periodic();
        test_full_table();
        test_random_traffic(160, 1'b1);
        test_random_traffic(60, 1'b0);
        test_random_traffic(90, 1'b1);
        test_random_traffic(50, 1'b0);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d requests: %0d add, %0d tick, %0d dispatch, %0d delete",
                 op_sent[OP_ADD] + op_sent[OP_TICK] + op_sent[OP_DISPATCH] + op_sent[OP_DELETE],
                 op_sent[OP_ADD], op_sent[OP_TICK], op_sent[OP_DISPATCH], op_sent[OP_DELETE]);
        $display("checked %0d results: %0d table full, %0d invalid slot, %0d nothing ready",
                 results_seen, status_seen[ST_FULL], status_seen[ST_BAD_SLOT],
                 status_seen[ST_NONE]);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d results still expected", mismatches,
                     pending_results.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
